/* design/bb3_pkg.sv */
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, widths and arithmetic helpers of the 3x3 box blur unit.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int ChW         = 8;
  localparam int PixW        = 3 * ChW;
  localparam int DimW        = 11;
  localparam int DataW       = 32;
  localparam int AddrW       = 3;
  localparam int WinN        = 9;
  localparam int CntW        = 4;
  localparam int RawSumW     = 12;
  localparam int SumW        = RawSumW + 1;
  localparam int RecipW      = 20;
  localparam int RecipShift  = 20;
  localparam int ProdW       = SumW + RecipW;
  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeightDef = 1024;

  localparam logic [DimW-1:0] WidthRst  = DimW'(640);
  localparam logic [DimW-1:0] HeightRst = DimW'(480);

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef logic [PixW-1:0] pix_t;

  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic            restart;
  } cfg_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } mask_t;

  function automatic logic [CntW-1:0] blk_count(input logic [1:0] rows,
                                                input logic [1:0] cols);
    logic [CntW-1:0] c;
    c = CntW'(cols);
    case (rows)
      2'd1:    return c;
      2'd2:    return c << 1;
      2'd3:    return c + (c << 1);
      default: return c;
    endcase
  endfunction

  // ceil(2^RecipShift / (2 * count)); exact floor for numerators below 2^SumW
  function automatic logic [RecipW-1:0] blk_recip(input logic [CntW-1:0] cnt);
    case (cnt)
      4'd1:    return RecipW'(524288);
      4'd2:    return RecipW'(262144);
      4'd3:    return RecipW'(174763);
      4'd4:    return RecipW'(131072);
      4'd6:    return RecipW'(87382);
      4'd9:    return RecipW'(58255);
      default: return RecipW'(524288);
    endcase
  endfunction

endpackage

/* design/bb3_stream_if.sv */
// ----------------------------------------------------------------------------
// bb3 stream interfaces
// Valid/ready channels for incoming pixels and blurred results.
// ----------------------------------------------------------------------------
interface bb3_pix_if;
  import bb3_pkg::*;

  logic           valid;
  logic           ready;
  logic [ChW-1:0] in_red;
  logic [ChW-1:0] in_green;
  logic [ChW-1:0] in_blue;
  logic           is_pad;

  modport source (output valid, in_red, in_green, in_blue, is_pad, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, is_pad, output ready);
  modport mon    (input valid, ready, in_red, in_green, in_blue, is_pad);
endinterface

interface bb3_res_if;
  import bb3_pkg::*;

  logic           valid;
  logic           ready;
  logic [ChW-1:0] out_red;
  logic [ChW-1:0] out_green;
  logic [ChW-1:0] out_blue;
  logic           frame_last;

  modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_last, output ready);
  modport mon    (input valid, ready, out_red, out_green, out_blue, frame_last);
endinterface

/* design/box_blur_3x3_stream_unit.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_stream_unit
// 3x3 box blur over an RGB raster stream with edge-normalised averaging.
// ----------------------------------------------------------------------------
// Each accepted pixel does one read-modify-write of the line memory at its
// column, so the unit handles one item at a time: an item with no result
// passes IDLE and CALC, one with a result IDLE, CALC, SUM and DIV, waiting
// in DIV while the result channel stalls; a pad that arrives before the
// frame is complete is taken and dropped. Results trail the input by one
// row plus one pixel; feed pad items after the last pixel to drain them.
// Writing either register restarts the frame. The line stores need no
// clearing after reset, since out-of-image neighbours are always masked.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream_unit #(
  parameter int MAX_WIDTH  = bb3_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = bb3_pkg::MaxHeightDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  bb3_pix_if.sink                   pix_i,
  bb3_res_if.source                 res_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bb3_pkg::AddrW-1:0] paddr,
  input  logic [bb3_pkg::DataW-1:0] pwdata,
  output logic [bb3_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import bb3_pkg::*;

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int RowW = $clog2(MAX_HEIGHT + 2);
  localparam int CmpA = (DimW > ColW) ? DimW : ColW;
  localparam int CmpW = ((CmpA > RowW) ? CmpA : RowW) + 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_DIV  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  cfg_t                cfg;
  logic [CmpW-1:0]     w_ext, h_ext, w_eff, h_eff;
  logic [ColW-1:0]     in_col_q, out_col_q;
  logic [RowW-1:0]     in_row_q, out_row_q;
  pix_t [WinN-1:0]     window_q;
  pix_t                pix_q;
  logic                emit_q, last_q;
  logic                out_valid_q;
  logic [2:0][ChW-1:0] out_pix_q;
  logic                out_last_q;
  logic [2*PixW-1:0]   mem_rdata;
  logic [2:0][ChW-1:0] avg;
  mask_t               mask;
  logic                accept, frame_open, ignore, emit_now;
  logic                col_wrap, out_col_wrap, out_row_last, frame_done;
  logic                out_load, restart;

  bb3_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign w_ext = CmpW'(cfg.width);
  assign h_ext = CmpW'(cfg.height);

  always_comb begin
    if (cfg.width == '0) begin
      w_eff = CmpW'(1);
    end else if (w_ext > CmpW'(MAX_WIDTH)) begin
      w_eff = CmpW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (cfg.height == '0) begin
      h_eff = CmpW'(1);
    end else if (h_ext > CmpW'(MAX_HEIGHT)) begin
      h_eff = CmpW'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
  end

  assign pix_i.ready  = (state_q == ST_IDLE);
  assign accept       = pix_i.valid & pix_i.ready;
  assign frame_open   = CmpW'(in_row_q) < h_eff;
  assign ignore       = frame_open & pix_i.is_pad;
  assign emit_now     = (in_row_q >= RowW'(2)) ||
                        ((in_row_q == RowW'(1)) && (in_col_q != '0));
  assign col_wrap     = (CmpW'(in_col_q) + CmpW'(1)) >= w_eff;
  assign out_col_wrap = (CmpW'(out_col_q) + CmpW'(1)) >= w_eff;
  assign out_row_last = (CmpW'(out_row_q) + CmpW'(1)) >= h_eff;
  assign frame_done   = out_col_wrap & out_row_last;
  assign out_load     = (state_q == ST_DIV) && (!out_valid_q || res_o.ready);
  assign restart      = cfg.restart || ((state_q == ST_SUM) && frame_done);

  assign mask.top    = (out_row_q != '0);
  assign mask.bottom = !out_row_last;
  assign mask.left   = (out_col_q != '0);
  assign mask.right  = !out_col_wrap;

  // entry holds {row above, current row} at one column
  bb3_line_mem #(
    .Depth (MAX_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (in_col_q),
    .rd_data_o (mem_rdata),
    .wr_en_i   (state_q == ST_CALC),
    .wr_addr_i (in_col_q),
    .wr_data_i ({mem_rdata[PixW-1:0], pix_q})
  );

  bb3_avg u_avg (
    .clk_i    (clk_i),
    .start_i  (state_q == ST_SUM),
    .window_i (window_q),
    .mask_i   (mask),
    .avg_o    (avg)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && !ignore) state_d = ST_CALC;
      end
      ST_CALC: state_d = emit_q ? ST_SUM : ST_IDLE;
      ST_SUM:  state_d = ST_DIV;
      ST_DIV: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      emit_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) emit_q <= emit_now;
      if (state_q == ST_SUM) last_q <= frame_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= frame_open ? {pix_i.in_red, pix_i.in_green, pix_i.in_blue} : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      window_q  <= '0;
    end else if (restart) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      window_q  <= '0;
    end else begin
      if (state_q == ST_CALC) begin
        for (int r = 0; r < 3; r++) begin
          window_q[3*r]   <= window_q[3*r+1];
          window_q[3*r+1] <= window_q[3*r+2];
        end
        window_q[2] <= mem_rdata[2*PixW-1:PixW];
        window_q[5] <= mem_rdata[PixW-1:0];
        window_q[8] <= pix_q;
        if (col_wrap) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + RowW'(1);
        end else begin
          in_col_q <= in_col_q + ColW'(1);
        end
      end
      if (state_q == ST_SUM) begin
        if (out_col_wrap) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + RowW'(1);
        end else begin
          out_col_q <= out_col_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q  <= avg;
      out_last_q <= last_q;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.out_red    = out_pix_q[2];
  assign res_o.out_green  = out_pix_q[1];
  assign res_o.out_blue   = out_pix_q[0];
  assign res_o.frame_last = out_last_q;

endmodule

/* design/bb3_apb_regs.sv */
// ----------------------------------------------------------------------------
// bb3_apb_regs
// APB register file holding image width and height.
// ----------------------------------------------------------------------------
module bb3_apb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bb3_pkg::AddrW-1:0]   paddr,
  input  logic [bb3_pkg::DataW-1:0]   pwdata,
  output logic [bb3_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output bb3_pkg::cfg_t               cfg_o
);
  import bb3_pkg::*;

  logic [DimW-1:0] width_q, width_d;
  logic [DimW-1:0] height_q, height_d;
  logic            wr_en;
  reg_idx_e        idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      case (idx)
        REG_WIDTH:  width_d  = pwdata[DimW-1:0];
        REG_HEIGHT: height_d = pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = DataW'(width_q);
      REG_HEIGHT: prdata = DataW'(height_q);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.width   = width_q;
  assign cfg_o.height  = height_q;
  assign cfg_o.restart = wr_en;

endmodule

/* design/bb3_line_mem.sv */
// ----------------------------------------------------------------------------
// bb3_line_mem
// Two line stores packed side by side in one synchronous memory.
// ----------------------------------------------------------------------------
module bb3_line_mem #(
  parameter int Depth = bb3_pkg::MaxWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [$clog2(Depth)-1:0]    rd_addr_i,
  output logic [2*bb3_pkg::PixW-1:0]  rd_data_o,
  input  logic                        wr_en_i,
  input  logic [$clog2(Depth)-1:0]    wr_addr_i,
  input  logic [2*bb3_pkg::PixW-1:0]  wr_data_i
);
  import bb3_pkg::*;

  logic [2*PixW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

/* design/bb3_avg.sv */
// ----------------------------------------------------------------------------
// bb3_avg
// Masked 3x3 window sum per channel and rounded division by the count.
// ----------------------------------------------------------------------------
module bb3_avg (
  input  logic                                    clk_i,
  input  logic                                    start_i,
  input  bb3_pkg::pix_t [bb3_pkg::WinN-1:0]       window_i,
  input  bb3_pkg::mask_t                          mask_i,
  output logic [2:0][bb3_pkg::ChW-1:0]            avg_o
);
  import bb3_pkg::*;

  logic [2:0]                rows_ok;
  logic [2:0]                cols_ok;
  logic [1:0]                n_rows;
  logic [1:0]                n_cols;
  logic [CntW-1:0]           cnt;
  logic [2:0][RawSumW-1:0]   sum;
  logic [2:0][SumW-1:0]      num_d;
  logic [2:0][SumW-1:0]      num_q;
  logic [RecipW-1:0]         recip_q;
  logic [2:0][ProdW-1:0]     prod;

  assign rows_ok = {mask_i.bottom, 1'b1, mask_i.top};
  assign cols_ok = {mask_i.right, 1'b1, mask_i.left};
  assign n_rows  = 2'd1 + 2'(mask_i.top) + 2'(mask_i.bottom);
  assign n_cols  = 2'd1 + 2'(mask_i.left) + 2'(mask_i.right);
  assign cnt     = blk_count(n_rows, n_cols);

  always_comb begin
    logic [2:0][RawSumW-1:0] row_sum;
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        row_sum[r] = '0;
        for (int c = 0; c < 3; c++) begin
          if (rows_ok[r] && cols_ok[c]) begin
            row_sum[r] = row_sum[r] + RawSumW'(window_i[3*r+c][ch*ChW +: ChW]);
          end
        end
      end
      sum[ch]   = row_sum[0] + row_sum[1] + row_sum[2];
      num_d[ch] = {sum[ch], 1'b0} + SumW'(cnt);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q   <= num_d;
      recip_q <= blk_recip(cnt);
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch]  = ProdW'(num_q[ch]) * ProdW'(recip_q);
      avg_o[ch] = prod[ch][RecipShift +: ChW];
    end
  end

endmodule

/* design/bb3_checker.sv */
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks of the box blur unit, bound to its top level.
// ----------------------------------------------------------------------------
module bb3_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      pix_valid_i,
  input logic                      pix_ready_i,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic [bb3_pkg::ChW-1:0]   res_red_i,
  input logic [bb3_pkg::ChW-1:0]   res_green_i,
  input logic [bb3_pkg::ChW-1:0]   res_blue_i,
  input logic                      res_last_i,
  input logic                      psel,
  input logic                      penable,
  input logic                      pwrite,
  input logic [bb3_pkg::AddrW-1:0] paddr,
  input logic [bb3_pkg::DataW-1:0] pwdata,
  input logic [bb3_pkg::DataW-1:0] prdata
);
  import bb3_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      $stable({res_red_i, res_green_i, res_blue_i, res_last_i}))
    else $error("result payload changed while stalled");

  a_res_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> !$past(pix_valid_i && pix_ready_i))
    else $error("result appeared right after an input transaction");

  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite |=>
      ($past(paddr[2]) != paddr[2]) || (prdata == DataW'($past(pwdata[DimW-1:0]))))
    else $error("register readback mismatch");

endmodule

bind box_blur_3x3_stream_unit bb3_checker u_bb3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_valid_i (pix_i.valid),
  .pix_ready_i (pix_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_red_i   (res_o.out_red),
  .res_green_i (res_o.out_green),
  .res_blue_i  (res_o.out_blue),
  .res_last_i  (res_o.frame_last),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);

/* tb/bb3_blur_checker.sv */
// ----------------------------------------------------------------------------
// bb3_blur_checker
// Watches the pixel, result and register channels of the 3x3 box blur unit.
// It keeps its own line stores, window and frame counters, works out the
// blurred pixel due, if any, for each accepted pixel transaction and compares
// each accepted result with the oldest pending one.
// ----------------------------------------------------------------------------
module bb3_blur_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  bb3_pix_if.mon                    pix_m,
  bb3_res_if.mon                    res_m,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [bb3_pkg::AddrW-1:0] paddr,
  input  logic [bb3_pkg::DataW-1:0] pwdata,
  output int unsigned               fail_cnt,
  output int unsigned               pending_cnt,
  output int unsigned               blur_cnt,
  output int unsigned               frame_cnt
);
  import bb3_pkg::*;

  typedef struct packed {
    logic [ChW-1:0] red;
    logic [ChW-1:0] green;
    logic [ChW-1:0] blue;
    logic           last;
  } blur_pix_t;

  localparam int unsigned MaxReports = 20;

  logic [DimW-1:0] width_reg;
  logic [DimW-1:0] height_reg;
  pix_t            line_a [MaxWidthDef];
  pix_t            line_b [MaxWidthDef];
  pix_t            win    [WinN];
  logic [DimW-1:0] col;
  logic [DimW-1:0] row;
  logic [19:0]     out_idx;

  blur_pix_t   pending_blur_q [$];
  blur_pix_t   got_pix;
  blur_pix_t   due_pix;
  int unsigned n_fail;
  int unsigned n_blur;
  int unsigned n_frame;

  function automatic int unsigned clamp_dim(logic [DimW-1:0] v, int unsigned maxv);
    if (v == '0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void restart_frame();
    col     = '0;
    row     = '0;
    out_idx = '0;
    foreach (win[i]) win[i] = '0;
  endfunction

  function automatic void flag_field(string fld, logic [ChW-1:0] due, logic [ChW-1:0] got);
    if (got !== due) begin
      n_fail++;
      if (n_fail <= MaxReports)
        $display("%0t: blurred pixel %0d, %s expected %0d got %0d",
                 $time, n_blur, fld, due, got);
    end
  endfunction

  task automatic blur_step(input pix_t pix_in, input logic pad);
    int unsigned w, h, total, pos, ro, co, cnt, sr, sg, sb, dr, dc, k;
    int          rr, cc;
    pix_t        pix, top_px, mid_px, v;
    blur_pix_t   res;
    w     = clamp_dim(width_reg, MaxWidthDef);
    h     = clamp_dim(height_reg, MaxHeightDef);
    total = w * h;
    pos   = row * w + col;
    pix   = '0;
    if (pos < total) begin
      if (pad) return;
      pix = pix_in;
    end

    top_px      = line_b[col];
    mid_px      = line_a[col];
    line_b[col] = mid_px;
    line_a[col] = pix;
    for (k = 0; k < 3; k++) begin
      win[3*k]   = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = top_px;
    win[5] = mid_px;
    win[8] = pix;

    col = col + 1'b1;
    if (col >= w) begin
      col = '0;
      row = row + 1'b1;
    end
    if (pos < w + 1) return;

    ro  = out_idx / w;
    co  = out_idx % w;
    sr  = 0;
    sg  = 0;
    sb  = 0;
    cnt = 0;
    for (dr = 0; dr < 3; dr++) begin
      for (dc = 0; dc < 3; dc++) begin
        rr = int'(ro) + int'(dr) - 1;
        cc = int'(co) + int'(dc) - 1;
        if (rr < 0 || rr >= int'(h) || cc < 0 || cc >= int'(w)) continue;
        v   = win[dr*3 + dc];
        sr += v[2*ChW +: ChW];
        sg += v[ChW +: ChW];
        sb += v[0 +: ChW];
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;

    out_idx  = out_idx + 1'b1;
    res.last = (out_idx >= total) || (out_idx == '0);
    if (res.last) begin
      restart_frame();
      n_frame++;
    end
    res.red   = ChW'((2*sr + cnt) / (2*cnt));
    res.green = ChW'((2*sg + cnt) / (2*cnt));
    res.blue  = ChW'((2*sb + cnt) / (2*cnt));
    pending_blur_q.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = WidthRst;
      height_reg = HeightRst;
      foreach (line_a[i]) begin
        line_a[i] = '0;
        line_b[i] = '0;
      end
      restart_frame();
      pending_blur_q.delete();
      n_fail      = 0;
      n_blur      = 0;
      n_frame     = 0;
      fail_cnt    <= 0;
      pending_cnt <= 0;
      blur_cnt    <= 0;
      frame_cnt   <= 0;
    end else begin
      if (res_m.valid && res_m.ready) begin
        got_pix = {res_m.out_red, res_m.out_green, res_m.out_blue, res_m.frame_last};
        if (pending_blur_q.size() == 0) begin
          n_fail++;
          if (n_fail <= MaxReports)
            $display("%0t: unexpected blurred pixel, expected none got %0d/%0d/%0d last=%0b",
                     $time, got_pix.red, got_pix.green, got_pix.blue, got_pix.last);
        end else begin
          due_pix = pending_blur_q.pop_front();
          flag_field("red", due_pix.red, got_pix.red);
          flag_field("green", due_pix.green, got_pix.green);
          flag_field("blue", due_pix.blue, got_pix.blue);
          flag_field("frame_last", ChW'(due_pix.last), ChW'(got_pix.last));
        end
        n_blur++;
      end

      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[2]))
          REG_WIDTH: begin
            width_reg = pwdata[DimW-1:0];
          end
          REG_HEIGHT: begin
            height_reg = pwdata[DimW-1:0];
          end
          default: begin
          end
        endcase
        restart_frame();
      end

      if (pix_m.valid && pix_m.ready)
        blur_step({pix_m.in_red, pix_m.in_green, pix_m.in_blue}, pix_m.is_pad);

      fail_cnt    <= n_fail;
      pending_cnt <= pending_blur_q.size();
      blur_cnt    <= n_blur;
      frame_cnt   <= n_frame;
    end
  end

endmodule

/* tb/tb_box_blur_3x3_stream_unit.sv */
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_stream_unit
// Drives pixel frames of many sizes through the 3x3 box blur unit: a short
// directed set of corner values, pads and degenerate sizes, a frame of the
// widest rows and a column of the tallest height, both cut short by a
// restart, then random frames with noise, broken frames and restarts.
// Sender bursts and receiver stalls vary throughout; the checker decides.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_stream_unit;
  import bb3_pkg::*;

  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned RandomItems  = 560;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned LongHold     = 400;

  typedef enum int unsigned {
    RX_ALWAYS,
    RX_HALF,
    RX_RARE,
    RX_MOSTLY
  } rx_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [AddrW-1:0]   paddr;
  logic [DataW-1:0]   pwdata;
  logic [DataW-1:0]   prdata;
  logic               pready;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned blur_cnt;
  int unsigned frame_cnt;
  int unsigned cycle_cnt  = 0;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned stall_reqs = 0;
  int unsigned stall_seen = 0;
  int unsigned hold_left  = 0;
  int unsigned rx_left    = 0;
  rx_mode_e    rx_mode    = RX_ALWAYS;

  logic [DimW-1:0] cur_w = WidthRst;
  logic [DimW-1:0] cur_h = HeightRst;

  pix_t corner_mix [9] = '{24'hFFFFFF, 24'h000000, 24'hFF00FF,
                           24'h000102, 24'h7F8081, 24'h00FF00,
                           24'hFFFFFF, 24'h010000, 24'hFEFEFE};

  bb3_pix_if pix_if ();
  bb3_res_if res_if ();

  box_blur_3x3_stream_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bb3_blur_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_m       (pix_if),
    .res_m       (res_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending),
    .blur_cnt    (blur_cnt),
    .frame_cnt   (frame_cnt)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (stall_seen != stall_reqs) begin
      stall_seen   <= stall_reqs;
      hold_left    <= LongHold;
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        rx_left <= $urandom_range(16, 160);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_ALWAYS: res_if.ready <= 1'b1;
        RX_HALF:   res_if.ready <= 1'($urandom_range(0, 1));
        RX_RARE:   res_if.ready <= ($urandom_range(0, 5) == 0);
        default:   res_if.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic int unsigned eff_dim(logic [DimW-1:0] v, int unsigned maxv);
    if (v == '0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [ChW-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return ChW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_t rand_pix();
    return {rand_chan(), rand_chan(), rand_chan()};
  endfunction

  task automatic send_item(input pix_t pix, input logic pad);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    pix_if.valid    <= 1'b1;
    pix_if.in_red   <= pix[2*ChW +: ChW];
    pix_if.in_green <= pix[ChW +: ChW];
    pix_if.in_blue  <= pix[0 +: ChW];
    pix_if.is_pad   <= pad;
    do @(posedge clk_i); while (!pix_if.ready);
  endtask

  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [DimW-1:0] val);
    logic [DataW-1:0] wd;
    wd            = $urandom();
    wd[DimW-1:0]  = val;
    if (idx == REG_WIDTH) cur_w = val;
    else cur_h = val;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= wd;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic new_dims(input logic [DimW-1:0] w, input logic [DimW-1:0] h);
    settle();
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
  endtask

  // pixels first, then the drain tail; noisy adds ignored pads and pauses
  task automatic feed_frame(input int unsigned n_pix, input int unsigned n_tail,
                            input bit noisy);
    int unsigned i;
    for (i = 0; i < n_pix; i++) begin
      if (noisy && $urandom_range(0, 29) == 0) send_item(rand_pix(), 1'b1);
      if (noisy && $urandom_range(0, 249) == 0) wait_drained();
      send_item(rand_pix(), 1'b0);
      items_sent++;
    end
    for (i = 0; i < n_tail; i++) begin
      send_item(rand_pix(), $urandom_range(0, 3) != 0);
      items_sent++;
    end
  endtask

  initial begin
    int unsigned     w_eff;
    int unsigned     h_eff;
    int unsigned     n_frames;
    int unsigned     rand_goal;
    int unsigned     f;
    logic [DimW-1:0] w_new;
    logic [DimW-1:0] h_new;

    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    pix_if.valid    = 1'b0;
    pix_if.in_red   = '0;
    pix_if.in_green = '0;
    pix_if.in_blue  = '0;
    pix_if.is_pad   = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3x3 frame of extremes, an early pad, a late pixel in the drain
    new_dims(DimW'(3), DimW'(3));
    foreach (corner_mix[i]) begin
      if (i == 4) send_item(24'h123456, 1'b1);
      send_item(corner_mix[i], 1'b0);
    end
    send_item('0, 1'b1);
    send_item(24'hC3A55A, 1'b0);
    send_item('1, 1'b1);
    send_item('0, 1'b1);

    // zero sizes act as a single pixel
    new_dims('0, '0);
    send_item(24'hABCDEF, 1'b0);
    send_item(rand_pix(), 1'b1);
    send_item(24'h5A5A5A, 1'b0);
    items_sent += 17;

    // widest rows, with a long result hold-off once results flow
    new_dims('1, DimW'(2));
    feed_frame(MaxWidthDef + 6, 0, 1'b0);
    stall_reqs <= stall_reqs + 1;
    feed_frame(40, 0, 1'b0);

    // single column open to the tallest height
    new_dims(DimW'(1), '1);
    feed_frame(150, 0, 1'b0);

    rand_goal = items_sent + RandomItems;
    while (items_sent < rand_goal) begin
      case ($urandom_range(0, 9))
        0:       w_new = '0;
        1:       w_new = DimW'(1);
        2:       w_new = DimW'(2);
        9:       w_new = DimW'($urandom_range(13, 32));
        default: w_new = DimW'($urandom_range(3, 12));
      endcase
      case ($urandom_range(0, 7))
        0:       h_new = '0;
        1:       h_new = DimW'(1);
        7:       h_new = DimW'($urandom_range(9, 16));
        default: h_new = DimW'($urandom_range(2, 8));
      endcase
      settle();
      case ($urandom_range(0, 4))
        0:       cfg_write(REG_WIDTH, w_new);
        1:       cfg_write(REG_HEIGHT, h_new);
        default: begin
          cfg_write(REG_HEIGHT, h_new);
          cfg_write(REG_WIDTH, w_new);
        end
      endcase
      w_eff    = eff_dim(cur_w, MaxWidthDef);
      h_eff    = eff_dim(cur_h, MaxHeightDef);
      n_frames = $urandom_range(1, 3);
      for (f = 0; f < n_frames; f++) begin
        if (f != 0 && items_sent >= rand_goal) break;
        if ($urandom_range(0, 9) == 0) begin
          feed_frame($urandom_range(0, w_eff * h_eff + w_eff - 1), 0, 1'b1);
          break;
        end
        feed_frame(w_eff * h_eff, w_eff + 1, 1'b1);
      end
    end

    settle();
    $display("checked %0d blurred pixels in %0d completed frames from %0d stimulus items",
             blur_cnt, frame_cnt, items_sent);
    $display("sizes from 1x1 to 1024-pixel rows and an open 1024-row column, with restarts");
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
